[hw/rtl/ipv4fv_pkg.sv]
// shared constants and types for the ipv4 frame validator
package ipv4fv_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;

  // byte positions of the captured header fields
  localparam logic [CountW-1:0] PosEtherHi  = 16'd12;
  localparam logic [CountW-1:0] PosEtherLo  = 16'd13;
  localparam logic [CountW-1:0] PosVerIhl   = 16'd14;
  localparam logic [CountW-1:0] PosTotLenHi = 16'd16;
  localparam logic [CountW-1:0] PosTotLenLo = 16'd17;
  localparam logic [CountW-1:0] PosProto    = 16'd23;

  localparam logic [CountW-1:0] CountMax   = 16'hffff;
  localparam logic [CountW-1:0] EthHdrLen  = 16'd14;
  localparam logic [CountW-1:0] MinFrameLen = 16'd34;

  localparam logic [15:0]      EtherTypeIpv4 = 16'h0800;
  localparam logic [ByteW-1:0] ProtoTcp      = 8'd6;
  localparam logic [ByteW-1:0] ProtoUdp      = 8'd17;
  localparam logic [3:0]       IpVersion4    = 4'd4;
  localparam logic [ByteW-1:0] VersionMask   = 8'hf0;
  localparam logic [ByteW-1:0] IhlMask       = 8'h0f;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } byte_item_t;

endpackage

[hw/rtl/ipv4fv_if.sv]
// valid/ready channel interfaces for frame bytes and accept results
interface ipv4fv_byte_if;
  logic                          valid;
  logic                          ready;
  logic [ipv4fv_pkg::ByteW-1:0]  data_byte;
  logic                          last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ipv4fv_result_if;
  logic valid;
  logic ready;
  logic accept;

  modport source (output valid, output accept, input ready);
  modport sink   (input valid, input accept, output ready);
endinterface

[hw/rtl/ipv4_l4_frame_validator_unit.sv]
// top level of the ipv4 tcp/udp frame validator
//
//   channel    dir  payload               transfer
//   byte_i     in   data_byte, last_byte  one frame byte
//   result_o   out  accept                one flag per frame, on its last byte
//
// one byte per cycle sustained while result_o is not stalled; a byte passes
// an input register, then the counter/capture/check logic writes the result
// register, so result valid follows the last byte through both registers.
// reset clears the byte counter, captured fields and both valid flags.
// a stalled result holds the parser; the input register keeps taking bytes
// until it too is full, then byte_i.ready drops.
module ipv4_l4_frame_validator_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  ipv4fv_byte_if.sink      byte_i,
  ipv4fv_result_if.source  result_o
);

  logic                   stage_valid;
  ipv4fv_pkg::byte_item_t stage_item;
  logic                   take;

  ipv4fv_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_i),
    .take_i  (take),
    .valid_o (stage_valid),
    .item_o  (stage_item)
  );

  ipv4fv_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (stage_valid),
    .item_i   (stage_item),
    .take_o   (take),
    .result_o (result_o)
  );

endmodule

[hw/rtl/ipv4fv_in_stage.sv]
// input register stage for incoming frame bytes
module ipv4fv_in_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  ipv4fv_byte_if.sink            byte_i,
  input  logic                   take_i,
  output logic                   valid_o,
  output ipv4fv_pkg::byte_item_t item_o
);

  logic                   valid_q, valid_d;
  ipv4fv_pkg::byte_item_t item_q, item_d;
  logic                   load;

  assign byte_i.ready = !valid_q || take_i;
  assign load         = byte_i.valid && byte_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d          = 1'b1;
      item_d.data_byte = byte_i.data_byte;
      item_d.last_byte = byte_i.last_byte;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[hw/rtl/ipv4fv_parser.sv]
// byte counter, header capture, frame check and result register
module ipv4fv_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  ipv4fv_pkg::byte_item_t item_i,
  output logic                   take_o,
  ipv4fv_result_if.source        result_o
);

  logic [ipv4fv_pkg::CountW-1:0] count_q, count_d;
  logic [15:0]                   ether_q, ether_d;
  logic [ipv4fv_pkg::ByteW-1:0]  ver_ihl_q, ver_ihl_d;
  logic [15:0]                   tot_len_q, tot_len_d;
  logic [ipv4fv_pkg::ByteW-1:0]  proto_q, proto_d;
  logic                          out_valid_q, out_valid_d;
  logic                          accept_q, accept_d;

  logic                          out_free;
  logic [ipv4fv_pkg::CountW-1:0] frame_len;
  logic [16:0]                   tot_plus_hdr;
  logic [5:0]                    ihl_bytes;
  logic [3:0]                    version;
  logic                          frame_ok;

  assign out_free = !out_valid_q || result_o.ready;
  assign take_o   = valid_i && out_free;

  // frame length including the current byte, saturating
  assign frame_len = (count_q == ipv4fv_pkg::CountMax) ? ipv4fv_pkg::CountMax
                                                       : count_q + 16'd1;

  // all captured fields lie below the minimum length, so registered state suffices
  assign version = 4'((ver_ihl_q & ipv4fv_pkg::VersionMask) >> 4);

  ipv4fv_ihl_len u_ihl_len (
    .ver_ihl_i   (ver_ihl_q),
    .ihl_bytes_o (ihl_bytes)
  );

  assign tot_plus_hdr = {1'b0, tot_len_q} + {1'b0, ipv4fv_pkg::EthHdrLen};

  assign frame_ok = (frame_len >= ipv4fv_pkg::MinFrameLen)
                 && (ether_q == ipv4fv_pkg::EtherTypeIpv4)
                 && ((proto_q == ipv4fv_pkg::ProtoTcp) || (proto_q == ipv4fv_pkg::ProtoUdp))
                 && (version == ipv4fv_pkg::IpVersion4)
                 && (tot_plus_hdr <= {1'b0, frame_len})
                 && (tot_len_q >= {10'd0, ihl_bytes});

  always_comb begin
    count_d     = count_q;
    ether_d     = ether_q;
    ver_ihl_d   = ver_ihl_q;
    tot_len_d   = tot_len_q;
    proto_d     = proto_q;
    out_valid_d = out_valid_q && !result_o.ready;
    accept_d    = accept_q;
    if (take_o) begin
      case (count_q)
        ipv4fv_pkg::PosEtherHi:  ether_d[15:8]   = item_i.data_byte;
        ipv4fv_pkg::PosEtherLo:  ether_d[7:0]    = item_i.data_byte;
        ipv4fv_pkg::PosVerIhl:   ver_ihl_d       = item_i.data_byte;
        ipv4fv_pkg::PosTotLenHi: tot_len_d[15:8] = item_i.data_byte;
        ipv4fv_pkg::PosTotLenLo: tot_len_d[7:0]  = item_i.data_byte;
        ipv4fv_pkg::PosProto:    proto_d         = item_i.data_byte;
        default: ;
      endcase
      if (item_i.last_byte) begin
        out_valid_d = 1'b1;
        accept_d    = frame_ok;
        count_d     = '0;
        ether_d     = '0;
        ver_ihl_d   = '0;
        tot_len_d   = '0;
        proto_d     = '0;
      end else begin
        count_d = frame_len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ether_q     <= '0;
      ver_ihl_q   <= '0;
      tot_len_q   <= '0;
      proto_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ether_q     <= ether_d;
      ver_ihl_q   <= ver_ihl_d;
      tot_len_q   <= tot_len_d;
      proto_q     <= proto_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    accept_q <= accept_d;
  end

  assign result_o.valid  = out_valid_q;
  assign result_o.accept = accept_q;

endmodule

[hw/rtl/ipv4l4fv_placeholder_unused.sv]
// header field check helper: ihl byte count
module ipv4fv_ihl_len (
  input  logic [7:0] ver_ihl_i,
  output logic [5:0] ihl_bytes_o
);
  assign ihl_bytes_o = {ver_ihl_i[3:0], 2'b00};
endmodule
